[hdl/hspd_pkg.sv]
// Shared types and constants for the humidity sensor pulse decoder.
package hspd_pkg;

  localparam int unsigned DurW        = 15;
  localparam int unsigned FrameSyms   = 41;
  localparam int unsigned DataBits    = 40;
  localparam int unsigned CountW      = 6;
  localparam int unsigned HumW        = 7;
  localparam int unsigned TempW       = 10;
  localparam int unsigned TempWideW   = 12;

  localparam logic [DurW-1:0]      ThresholdReset = 15'd35;
  localparam logic [CountW-1:0]    CountMax       = 6'd63;
  localparam logic [CountW-1:0]    CountFrame     = 6'd41;
  localparam logic [7:0]           HumLimit       = 8'd100;
  localparam logic [TempWideW-1:0] TempLimit      = 12'd600;
  localparam logic [TempWideW-1:0] Tens           = 12'd10;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StShort    = 2'd1,
    StChecksum = 2'd2
  } status_e;

  // Snapshot of one finished frame, handed from the accumulator to the decoder.
  typedef struct packed {
    logic [FrameSyms-1:0] bits;
    logic [CountW-1:0]    count;
  } frame_t;

endpackage

[hdl/hspd_frame.sv]
// Symbol slicer and frame accumulator with its frame snapshot register.
module hspd_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hspd_pkg::DurW-1:0]     threshold_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          level_first_i,
  input  logic [hspd_pkg::DurW-1:0]     duration_first_i,
  input  logic [hspd_pkg::DurW-1:0]     duration_second_i,
  input  logic                          last_i,
  output logic                          frame_valid_o,
  input  logic                          frame_ready_i,
  output hspd_pkg::frame_t              frame_o
);
  import hspd_pkg::*;

  logic [FrameSyms-1:0] store_q, store_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 frame_valid_q;
  frame_t               frame_q;
  logic [DurW-1:0]      high_dur;
  logic                 sym_bit;
  logic                 accept;

  assign in_ready_o = !frame_valid_q || frame_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign high_dur = level_first_i ? duration_first_i : duration_second_i;
  assign sym_bit  = (high_dur >= threshold_i);

  always_comb begin
    for (int k = 0; k < FrameSyms; k++) begin
      store_d[k] = store_q[k] | (sym_bit && (count_q == CountW'(k)));
    end
    count_d = (count_q != CountMax) ? count_q + 1'b1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q       <= '0;
      count_q       <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (last_i) begin
          store_q <= '0;
          count_q <= '0;
        end else begin
          store_q <= store_d;
          count_q <= count_d;
        end
      end
      if (accept && last_i) begin
        frame_valid_q <= 1'b1;
      end else if (frame_ready_i) begin
        frame_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      frame_q.bits  <= store_d;
      frame_q.count <= count_d;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

[hdl/hspd_decode.sv]
// Frame decoder: bit alignment, checksum, range checks and result register.
module hspd_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          frame_valid_i,
  output logic                          frame_ready_o,
  input  hspd_pkg::frame_t              frame_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hspd_pkg::status_e             status_o,
  output logic [hspd_pkg::HumW-1:0]     humidity_o,
  output logic                          humidity_valid_o,
  output logic [hspd_pkg::TempW-1:0]    temperature_tenths_o,
  output logic                          temperature_valid_o
);
  import hspd_pkg::*;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [HumW-1:0]      hum_q, hum_d;
  logic                 hum_ok_q, hum_ok_d;
  logic [TempW-1:0]     temp_q, temp_d;
  logic                 temp_ok_q, temp_ok_d;
  logic                 load;
  logic [DataBits-1:0]  word;
  logic [7:0]           hum_hi, hum_lo, tmp_hi, tmp_lo, chk, sum;
  logic [TempWideW-1:0] temp_wide;
  logic                 skip_first;

  assign frame_ready_o = !out_valid_q || out_ready_i;
  assign load          = frame_valid_i && frame_ready_o;

  // With more than a full frame the leading symbol is the start response.
  assign skip_first = (frame_i.count != CountFrame);

  always_comb begin
    for (int k = 0; k < DataBits; k++) begin
      word[DataBits-1-k] = skip_first ? frame_i.bits[k+1] : frame_i.bits[k];
    end
  end

  assign hum_hi    = word[39:32];
  assign hum_lo    = word[31:24];
  assign tmp_hi    = word[23:16];
  assign tmp_lo    = word[15:8];
  assign chk       = word[7:0];
  assign sum       = hum_hi + hum_lo + tmp_hi + tmp_lo;
  assign temp_wide = ({4'b0, tmp_hi} * Tens) + {4'b0, tmp_lo};

  always_comb begin
    status_d  = StOk;
    hum_d     = '0;
    hum_ok_d  = 1'b0;
    temp_d    = '0;
    temp_ok_d = 1'b0;
    if (frame_i.count < CountFrame) begin
      status_d = StShort;
    end else if (sum != chk) begin
      status_d = StChecksum;
    end else begin
      if (hum_hi <= HumLimit) begin
        hum_d    = hum_hi[HumW-1:0];
        hum_ok_d = 1'b1;
      end
      if (temp_wide <= TempLimit) begin
        temp_d    = temp_wide[TempW-1:0];
        temp_ok_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      hum_q     <= hum_d;
      hum_ok_q  <= hum_ok_d;
      temp_q    <= temp_d;
      temp_ok_q <= temp_ok_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign humidity_o           = hum_q;
  assign humidity_valid_o     = hum_ok_q;
  assign temperature_tenths_o = temp_q;
  assign temperature_valid_o  = temp_ok_q;

endmodule

[hdl/humidity_sensor_pulse_decoder_core.sv]
// Top level of the humidity sensor pulse decoder.
// Each input item is one captured pulse symbol. Its high-phase duration is
// compared against the bit threshold register to give one data bit, which is
// placed into a 41-bit frame store while a saturating symbol count advances.
// An item marked last closes the frame and produces exactly one result item
// (status, humidity, temperature in tenths and their valid flags); other items
// produce none. A new item is taken every cycle while the result path flows:
// the slicer and accumulator update in the accepting cycle, the finished frame
// sits in a snapshot register, and the decoder (alignment, checksum add, one
// multiply by ten and the range compares) fills the result register. The
// snapshot loads on the edge that takes the last symbol, and the result register
// loads from the snapshot once the decoder can take the frame. The frame
// snapshot and the result register each act as a holding stage, so symbols of
// the next frame keep flowing while a result waits; input stalls only when
// both hold an undelivered frame. Write the threshold only while the block
// is idle.
module humidity_sensor_pulse_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // threshold register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hspd_pkg::DurW-1:0]     cfg_bit_threshold_i,
  // symbol input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          level_first_i,
  input  logic [hspd_pkg::DurW-1:0]     duration_first_i,
  input  logic [hspd_pkg::DurW-1:0]     duration_second_i,
  input  logic                          last_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [hspd_pkg::HumW-1:0]     humidity_o,
  output logic                          humidity_valid_o,
  output logic [hspd_pkg::TempW-1:0]    temperature_tenths_o,
  output logic                          temperature_valid_o
);
  import hspd_pkg::*;

  logic [DurW-1:0] threshold_q;
  logic            frame_valid;
  logic            frame_ready;
  frame_t          frame;
  status_e         status;

  // Accept threshold writes in any cycle; hold the value until the next write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      threshold_q <= cfg_bit_threshold_i;
    end
  end

  // Slice each symbol to a bit and gather the frame.
  hspd_frame u_frame (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .threshold_i       (threshold_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .level_first_i     (level_first_i),
    .duration_first_i  (duration_first_i),
    .duration_second_i (duration_second_i),
    .last_i            (last_i),
    .frame_valid_o     (frame_valid),
    .frame_ready_i     (frame_ready),
    .frame_o           (frame)
  );

  // Decode the closed frame into one result item.
  hspd_decode u_decode (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .frame_valid_i        (frame_valid),
    .frame_ready_o        (frame_ready),
    .frame_i              (frame),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status),
    .humidity_o           (humidity_o),
    .humidity_valid_o     (humidity_valid_o),
    .temperature_tenths_o (temperature_tenths_o),
    .temperature_valid_o  (temperature_valid_o)
  );

  assign status_o = status;

endmodule

[hdl/hspd_checker.sv]
// Port-level checks for the humidity sensor pulse decoder, bound to the top.
module hspd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [hspd_pkg::HumW-1:0]     humidity_o,
  input logic                          humidity_valid_o,
  input logic [hspd_pkg::TempW-1:0]    temperature_tenths_o,
  input logic                          temperature_valid_o
);
  import hspd_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A failed frame carries no readings.
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |->
      !humidity_valid_o && !temperature_valid_o &&
      (humidity_o == '0) && (temperature_tenths_o == '0))
    else $error("readings present on failed frame");

  // Humidity is in range when flagged and zero otherwise.
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (humidity_valid_o ? (humidity_o <= HumLimit[HumW-1:0]) : (humidity_o == '0)))
    else $error("humidity out of range or not cleared");

  // Temperature is in range when flagged and zero otherwise.
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (temperature_valid_o ? (temperature_tenths_o <= TempLimit[TempW-1:0])
                           : (temperature_tenths_o == '0)))
    else $error("temperature out of range or not cleared");

endmodule

bind humidity_sensor_pulse_decoder_core hspd_checker u_hspd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .status_o             (status_o),
  .humidity_o           (humidity_o),
  .humidity_valid_o     (humidity_valid_o),
  .temperature_tenths_o (temperature_tenths_o),
  .temperature_valid_o  (temperature_valid_o)
);
